// ----- sv/lru_pkg.sv -----
package lru_pkg;

    localparam int CFG_W         = 4;
    localparam int PAGE_PORT_W   = 16;
    localparam int FRAME_INDEX_W = 3;
    localparam int COUNT_W       = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

// ----- sv/lru_page_replacement.sv -----
// LRU page replacement tracker. Each request carries one page number; the block
// answers with one result: hit or fault, the frame that holds the page afterward,
// the page evicted (if any) and saturating hit and fault totals. Frame pages and
// last-use stamps live in a single-port synchronous memory that is scanned one
// frame per cycle over the n frames in use (frames_in_use, 0 taken as 1, clamped
// to FRAMES): each frame read is registered and then compared, then the chosen
// frame is written back once the output register is free, and the block returns
// to idle to take the next request. A finished result sits
// in the output register while the next request is taken and scanned. Frame
// valid bits are flip-flops cleared at reset; frames_in_use resets to 8 and may be
// written only while no request is in flight.
module lru_page_replacement
    import lru_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         frames_in_use,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [PAGE_PORT_W-1:0]   page_number,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [FRAME_INDEX_W-1:0] frame_index,
    output logic                     evicted_valid,
    output logic [PAGE_PORT_W-1:0]   evicted_page,
    output logic [COUNT_W-1:0]       hit_count,
    output logic [COUNT_W-1:0]       fault_count
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = IW + 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     cfg_reg;
    logic [FRAMES-1:0]    valid_reg;
    logic [COUNT_W-1:0]   req_reg;
    logic [COUNT_W-1:0]   hit_total_reg;
    logic [COUNT_W-1:0]   fault_total_reg;
    logic [PAGE_BITS-1:0] page_reg;

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [COUNT_W-1:0]   lu_mem   [FRAMES];
    logic [PAGE_BITS-1:0] rd_page_reg;
    logic [COUNT_W-1:0]   rd_lu_reg;

    logic [CW-1:0]        issue_reg;
    logic                 cmp_valid_reg;
    logic [IW-1:0]        cmp_idx_reg;

    logic                 found_reg;
    logic [IW-1:0]        hit_slot_reg;
    logic                 empty_reg;
    logic [IW-1:0]        empty_slot_reg;
    logic [COUNT_W-1:0]   min_lu_reg;
    logic [IW-1:0]        min_slot_reg;
    logic [PAGE_BITS-1:0] min_page_reg;

    logic                     out_valid_reg;
    logic                     hit_reg;
    logic [FRAME_INDEX_W-1:0] frame_index_reg;
    logic                     evicted_valid_reg;
    logic [PAGE_PORT_W-1:0]   evicted_page_reg;

    logic [CW-1:0]        n_active;
    logic                 issue_live;
    logic                 cmp_last;
    logic                 e_valid;
    logic                 e_hit;
    logic                 first;
    logic [IW-1:0]        slot;
    logic                 commit;
    logic                 accept;
    logic [31:0]          slot_ext;
    logic [63:0]          min_page_ext;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_active = CW'(1);
        end
        else if (32'(cfg_reg) > FRAMES)
        begin
            n_active = CW'(FRAMES);
        end
        else
        begin
            n_active = CW'(cfg_reg);
        end
    end

    assign issue_live   = (state_reg == ST_SCAN) && (issue_reg < n_active);
    assign cmp_last     = cmp_valid_reg && ((CW'(cmp_idx_reg) + CW'(1)) == n_active);
    assign e_valid      = valid_reg[cmp_idx_reg];
    assign e_hit        = e_valid && (rd_page_reg == page_reg);
    assign first        = (cmp_idx_reg == '0);
    assign slot         = found_reg ? hit_slot_reg : (empty_reg ? empty_slot_reg : min_slot_reg);
    assign slot_ext     = 32'(slot);
    assign min_page_ext = 64'(min_page_reg);
    assign accept       = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg         <= CFG_RESET;
            valid_reg       <= '0;
            req_reg         <= '0;
            hit_total_reg   <= '0;
            fault_total_reg <= '0;
            issue_reg       <= '0;
            cmp_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= frames_in_use;
            end
            if (accept)
            begin
                issue_reg <= '0;
            end
            else if (issue_live)
            begin
                issue_reg <= issue_reg + CW'(1);
            end
            cmp_valid_reg <= issue_live;
            if (out_valid_reg && out_ready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                valid_reg[slot] <= 1'b1;
                req_reg         <= req_reg + COUNT_W'(1);
                out_valid_reg   <= 1'b1;
                if (found_reg)
                begin
                    if (hit_total_reg != COUNT_MAX)
                    begin
                        hit_total_reg <= hit_total_reg + COUNT_W'(1);
                    end
                end
                else if (fault_total_reg != COUNT_MAX)
                begin
                    fault_total_reg <= fault_total_reg + COUNT_W'(1);
                end
            end
        end
    end

    // frame memory: read one frame per scan cycle, write back once per request
    always_ff @(posedge clk)
    begin
        if (issue_live)
        begin
            rd_page_reg <= page_mem[issue_reg[IW-1:0]];
            rd_lu_reg   <= lu_mem[issue_reg[IW-1:0]];
        end
        if (commit)
        begin
            page_mem[slot] <= page_reg;
            lu_mem[slot]   <= req_reg;
        end
    end

    // scan datapath and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= PAGE_BITS'(page_number);
        end
        cmp_idx_reg <= issue_reg[IW-1:0];
        if (cmp_valid_reg)
        begin
            if (first)
            begin
                found_reg      <= e_hit;
                hit_slot_reg   <= cmp_idx_reg;
                empty_reg      <= !e_valid;
                empty_slot_reg <= cmp_idx_reg;
                min_lu_reg     <= rd_lu_reg;
                min_slot_reg   <= cmp_idx_reg;
                min_page_reg   <= rd_page_reg;
            end
            else
            begin
                if (!found_reg && e_hit)
                begin
                    found_reg    <= 1'b1;
                    hit_slot_reg <= cmp_idx_reg;
                end
                if (!empty_reg && !e_valid)
                begin
                    empty_reg      <= 1'b1;
                    empty_slot_reg <= cmp_idx_reg;
                end
                if (rd_lu_reg < min_lu_reg)
                begin
                    min_lu_reg   <= rd_lu_reg;
                    min_slot_reg <= cmp_idx_reg;
                    min_page_reg <= rd_page_reg;
                end
            end
        end
        if (commit)
        begin
            hit_reg           <= found_reg;
            frame_index_reg   <= slot_ext[FRAME_INDEX_W-1:0];
            evicted_valid_reg <= !found_reg && !empty_reg;
            evicted_page_reg  <= (!found_reg && !empty_reg) ?
                                 min_page_ext[PAGE_PORT_W-1:0] : '0;
        end
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign hit_count     = hit_total_reg;
    assign fault_count   = fault_total_reg;

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result appeared without a write-back");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && evicted_valid_reg))
        else $error("hit reported with an eviction");

    a_totals_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_total_reg != $past(hit_total_reg) || fault_total_reg != $past(fault_total_reg))
        |-> $past(commit))
        else $error("totals changed outside write-back");

    a_one_request_counted: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> !(hit_total_reg != $past(hit_total_reg)
                     && fault_total_reg != $past(fault_total_reg)))
        else $error("request counted as both hit and fault");

endmodule
